>>> rtl/delimited_message_receiver_core_assert.svh
// assertion macros used by the checker file
`ifndef DELIMITED_MESSAGE_RECEIVER_CORE_ASSERT_SVH
`define DELIMITED_MESSAGE_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define DMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dmr_pkg.sv
`timescale 1ns / 1ps

package dmr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_MSG  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ILLEGAL = 2'd1,
    ERR_COUNT   = 2'd2,
    ERR_LENGTH  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP  = 2'd1;
  localparam logic [1:0] REG_SEP   = 2'd2;

  localparam logic [7:0] START_RESET = 8'd60;
  localparam logic [7:0] STOP_RESET  = 8'd62;
  localparam logic [7:0] SEP_RESET   = 8'd44;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef struct packed {
    logic       message_ready;
    logic [3:0] item_count;
    err_t       error_code;
    logic       rd_ok;
  } stat_t;

endpackage

>>> rtl/dmr_ctrl.sv
`timescale 1ns / 1ps

module dmr_ctrl #(
  parameter int MAX_ITEMS    = 8,
  parameter int MAX_ITEM_LEN = 16,
  localparam int CNTW = $clog2(MAX_ITEMS + 1),
  localparam int LW   = $clog2(MAX_ITEM_LEN + 1),
  localparam int IW   = $clog2(MAX_ITEMS),
  localparam int AW   = $clog2(MAX_ITEMS * MAX_ITEM_LEN)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               step,
  input  logic [1:0]         cmd,
  input  logic [7:0]         byte_in,
  input  logic [2:0]         item_index,
  output dmr_pkg::stat_t     stat,
  output logic               char_we,
  output logic [AW-1:0]      char_waddr,
  output logic [7:0]         char_wdata,
  output logic               len_we,
  output logic [IW-1:0]      len_waddr,
  output logic [LW-1:0]      len_wdata
);

  localparam int CMPW = (CNTW > 3) ? CNTW : 3;

  dmr_pkg::phase_t phase_r, phase_nxt;
  dmr_pkg::err_t   err_r, err_nxt;
  logic [CNTW-1:0] items_r, items_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic [7:0]      start_r, stop_r, sep_r;

  logic            is_blank;
  logic            abort;
  dmr_pkg::err_t   abort_err;
  logic            close_item;
  logic            store_char;

  assign is_blank = (byte_in == dmr_pkg::CHAR_NL) || (byte_in == dmr_pkg::CHAR_SPACE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= dmr_pkg::START_RESET;
      stop_r  <= dmr_pkg::STOP_RESET;
      sep_r   <= dmr_pkg::SEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmr_pkg::REG_START: start_r <= cfg_wdata;
        dmr_pkg::REG_STOP:  stop_r  <= cfg_wdata;
        dmr_pkg::REG_SEP:   sep_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // command and byte decode
  always_comb begin
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    abort      = 1'b0;
    abort_err  = dmr_pkg::ERR_NONE;
    close_item = 1'b0;
    store_char = 1'b0;
    unique case (dmr_pkg::cmd_t'(cmd))
      dmr_pkg::CMD_PUSH: begin
        if (byte_in != dmr_pkg::CHAR_NUL) begin
          unique case (phase_r)
            dmr_pkg::PH_IDLE: begin
              if (byte_in == start_r) begin
                abort     = 1'b1;
                abort_err = dmr_pkg::ERR_NONE;
                phase_nxt = dmr_pkg::PH_RECV;
              end else if (!is_blank) begin
                abort     = 1'b1;
                abort_err = dmr_pkg::ERR_ILLEGAL;
                phase_nxt = dmr_pkg::PH_IDLE;
              end
            end
            dmr_pkg::PH_RECV: begin
              if (byte_in == start_r) begin
                abort     = 1'b1;
                abort_err = dmr_pkg::ERR_ILLEGAL;
                phase_nxt = dmr_pkg::PH_IDLE;
              end else if (byte_in == stop_r) begin
                close_item = (pos_r != '0);
                phase_nxt  = dmr_pkg::PH_MSG;
              end else if (byte_in == sep_r) begin
                if (pos_r == '0) begin
                  abort     = 1'b1;
                  abort_err = dmr_pkg::ERR_LENGTH;
                  phase_nxt = dmr_pkg::PH_IDLE;
                end else if (items_r >= CNTW'(MAX_ITEMS - 1)) begin
                  abort     = 1'b1;
                  abort_err = dmr_pkg::ERR_COUNT;
                  phase_nxt = dmr_pkg::PH_IDLE;
                end else begin
                  close_item = 1'b1;
                end
              end else if (pos_r >= LW'(MAX_ITEM_LEN)) begin
                abort     = 1'b1;
                abort_err = dmr_pkg::ERR_LENGTH;
                phase_nxt = dmr_pkg::PH_IDLE;
              end else if (!is_blank && (items_r < CNTW'(MAX_ITEMS))) begin
                store_char = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      dmr_pkg::CMD_CLEAR: begin
        abort     = 1'b1;
        abort_err = dmr_pkg::ERR_NONE;
        phase_nxt = dmr_pkg::PH_IDLE;
      end
      dmr_pkg::CMD_READ: ;
      dmr_pkg::CMD_NOP:  ;
      default: ;
    endcase
  end

  always_comb begin
    items_nxt = items_r;
    pos_nxt   = pos_r;
    if (abort) begin
      items_nxt = '0;
      pos_nxt   = '0;
    end else if (store_char) begin
      pos_nxt = pos_r + LW'(1);
    end else if (phase_nxt == dmr_pkg::PH_MSG && phase_r == dmr_pkg::PH_RECV) begin
      pos_nxt = '0;
      if (close_item && (items_r < CNTW'(MAX_ITEMS))) begin
        items_nxt = items_r + CNTW'(1);
      end
    end else if (close_item) begin
      items_nxt = items_r + CNTW'(1);
      pos_nxt   = '0;
    end
  end

  assign char_we    = step && store_char;
  assign char_waddr = AW'(32'(items_r) * 32'(MAX_ITEM_LEN) + 32'(pos_r));
  assign char_wdata = byte_in;
  assign len_we     = step && close_item && (items_r < CNTW'(MAX_ITEMS));
  assign len_waddr  = IW'(items_r);
  assign len_wdata  = pos_r;

  always_comb begin
    stat.message_ready = (phase_nxt == dmr_pkg::PH_MSG);
    stat.item_count    = stat.message_ready ? 4'(items_nxt) : 4'd0;
    stat.error_code    = abort ? abort_err : err_nxt;
    stat.rd_ok         = (dmr_pkg::cmd_t'(cmd) == dmr_pkg::CMD_READ) &&
                         (phase_r == dmr_pkg::PH_MSG) &&
                         (CMPW'(item_index) < CMPW'(items_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dmr_pkg::PH_IDLE;
      err_r   <= dmr_pkg::ERR_NONE;
      items_r <= '0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      err_r   <= abort ? abort_err : err_nxt;
      items_r <= items_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

>>> rtl/delimited_message_receiver_core.sv
// an input transfer's result is held in the s1 registers, then in the output register
// one item per cycle with out_tready high; state update and both memory reads run in parallel
// the character store and length table are synchronous memories, read into registers at accept
// a stalled output holds the pipeline; input is taken while the output register drains
// reset (rst_n low, synchronous): idle, no error, registers at '<' '>' ',', pipeline empty
`timescale 1ns / 1ps

module delimited_message_receiver_core #(
  parameter int MAX_ITEMS    = 8,
  parameter int MAX_ITEM_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_in, item_index, char_index, zero pad
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // message_ready, item_count, error_code, read_char, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int LW    = $clog2(MAX_ITEM_LEN + 1);
  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int DEPTH = MAX_ITEMS * MAX_ITEM_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP2  = (LW > 4) ? LW : 4;

  logic [7:0]      byte_in;
  logic [2:0]      item_index;
  logic [3:0]      char_index;
  logic            in_fire;

  dmr_pkg::stat_t  stat;
  logic            char_we;
  logic [AW-1:0]   char_waddr;
  logic [7:0]      char_wdata;
  logic            len_we;
  logic [IW-1:0]   len_waddr;
  logic [LW-1:0]   len_wdata;
  logic [AW-1:0]   char_raddr;
  logic [IW-1:0]   len_raddr;

  logic [7:0]      char_mem [DEPTH];
  logic [LW-1:0]   len_mem [MAX_ITEMS];

  logic            s1_valid_r, s1_valid_nxt;
  dmr_pkg::stat_t  s1_stat_r;
  logic [3:0]      s1_pos_r;
  logic [7:0]      char_rd_r;
  logic [LW-1:0]   len_rd_r;
  logic            s1_move;
  logic [7:0]      read_char;

  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_data_r;

  assign byte_in    = in_tdata[7:0];
  assign item_index = in_tdata[10:8];
  assign char_index = in_tdata[14:11];

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_fire   = in_tvalid && in_tready;

  dmr_ctrl #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_ITEM_LEN (MAX_ITEM_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step       (in_fire),
    .cmd        (in_tuser),
    .byte_in    (byte_in),
    .item_index (item_index),
    .stat       (stat),
    .char_we    (char_we),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .len_we     (len_we),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata)
  );

  // writes only happen while receiving and reads only count once held,
  // so one transfer never reads what the same cycle writes
  assign char_raddr = AW'(32'(item_index) * 32'(MAX_ITEM_LEN) + 32'(char_index));
  assign len_raddr  = IW'(item_index);

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (in_fire) begin
      char_rd_r <= char_mem[char_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (in_fire) begin
      len_rd_r <= len_mem[len_raddr];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stat_r <= stat;
      s1_pos_r  <= char_index;
    end
  end

  assign read_char = (s1_stat_r.rd_ok && (CMP2'(s1_pos_r) < CMP2'(len_rd_r))) ? char_rd_r
                                                                              : 8'd0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= {1'b0, read_char, s1_stat_r.error_code, s1_stat_r.item_count,
                     s1_stat_r.message_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/dmr_checker.sv
`timescale 1ns / 1ps
`include "delimited_message_receiver_core_assert.svh"

module dmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `DMR_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `DMR_ASSERT_IMP(a_count_ready, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[4:1] == 4'd0, "item count without message")
  `DMR_ASSERT_IMP(a_char_ready, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[14:7] == 8'd0, "character read without message")
  `DMR_ASSERT_IMP(a_ready_noerr, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[6:5] == 2'd0, "held message with error")

endmodule

bind delimited_message_receiver_core dmr_checker u_dmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/delimited_message_receiver_core_test.sv
`timescale 1ns / 1ps

module delimited_message_receiver_core_test;
  import dmr_pkg::*;

  localparam int MAX_ITEMS    = 8;
  localparam int MAX_ITEM_LEN = 16;
  localparam int PIPE_LATENCY = 2;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1670;
  localparam int CFG_PERIOD   = 400;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int FAULT_NONE      = 0;
  localparam int FAULT_OVERLONG  = 1;
  localparam int FAULT_TOO_MANY  = 2;
  localparam int FAULT_EMPTY     = 3;
  localparam int FAULT_RESTART   = 4;
  localparam int FAULT_STRAY     = 5;
  localparam int FAULT_FULL_BLNK = 6;

  typedef struct {
    logic       ready;
    logic [3:0] count;
    err_t       err;
    logic [7:0] rc;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // byte_in, item_index, char_index, zero pad
  logic [1:0]  in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // message_ready, item_count, error_code, read_char, zero pad
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  delimited_message_receiver_core #(
    .MAX_ITEMS   (MAX_ITEMS),
    .MAX_ITEM_LEN(MAX_ITEM_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // receiver state as predicted
  phase_t     msg_phase;
  err_t       msg_error;
  int         items_closed;
  int         fill_pos;
  int         item_len [MAX_ITEMS];
  logic [7:0] char_mem [MAX_ITEMS*MAX_ITEM_LEN];
  logic [7:0] open_char;
  logic [7:0] close_char;
  logic [7:0] split_char;

  status_t status_q[$];
  status_t want;
  int      mismatches;
  int      items_sent;
  int      results_seen;
  int      held_seen;
  int      err_seen [4];
  int      idle_cycles;
  int      hold_cycles;
  bit      tx_pressure;
  bit      rx_pressure;

  function automatic void drop_message(err_t code);
    items_closed = 0;
    fill_pos     = 0;
    item_len     = '{default: 0};
    msg_phase    = PH_IDLE;
    msg_error    = code;
  endfunction

  function automatic void reset_model();
    open_char  = START_RESET;
    close_char = STOP_RESET;
    split_char = SEP_RESET;
    drop_message(ERR_NONE);
  endfunction

  function automatic void write_model_reg(logic [1:0] idx, logic [7:0] v);
    case (idx)
      REG_START: open_char = v;
      REG_STOP:  close_char = v;
      REG_SEP:   split_char = v;
      default:   ;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CHAR_NL || b == CHAR_SPACE;
  endfunction

  function automatic void close_item();
    if (items_closed < MAX_ITEMS) begin
      item_len[items_closed] = fill_pos;
      items_closed++;
    end
    fill_pos = 0;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (b != CHAR_NUL) begin
      case (msg_phase)
        PH_IDLE: begin
          if (b == open_char) begin
            drop_message(ERR_NONE);
            msg_phase = PH_RECV;
          end else if (!is_blank(b)) begin
            drop_message(ERR_ILLEGAL);
          end
        end
        PH_RECV: begin
          if (b == open_char) begin
            drop_message(ERR_ILLEGAL);
          end else if (b == close_char) begin
            if (fill_pos > 0) close_item();
            msg_phase = PH_MSG;
          end else if (b == split_char) begin
            if (fill_pos == 0) drop_message(ERR_LENGTH);
            else if (items_closed >= MAX_ITEMS - 1) drop_message(ERR_COUNT);
            else close_item();
          end else if (fill_pos >= MAX_ITEM_LEN) begin
            drop_message(ERR_LENGTH);
          end else if (!is_blank(b) && items_closed < MAX_ITEMS) begin
            char_mem[items_closed*MAX_ITEM_LEN + fill_pos] = b;
            fill_pos++;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic logic [7:0] stored_char(logic [2:0] it, logic [3:0] ch);
    if (msg_phase != PH_MSG || int'(it) >= items_closed) return 8'd0;
    if (int'(ch) >= item_len[it]) return 8'd0;
    return char_mem[int'(it)*MAX_ITEM_LEN + int'(ch)];
  endfunction

  function automatic status_t predict_status(cmd_t cmd, logic [7:0] b, logic [2:0] it,
                                             logic [3:0] ch);
    status_t s;
    s.rc = 8'd0;
    case (cmd)
      CMD_PUSH:  take_byte(b);
      CMD_READ:  s.rc = stored_char(it, ch);
      CMD_CLEAR: drop_message(ERR_NONE);
      default:   ;
    endcase
    s.ready = (msg_phase == PH_MSG);
    s.count = s.ready ? 4'(items_closed) : 4'd0;
    s.err   = msg_error;
    return s;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("result %0d: %s", results_seen, msg);
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val)
      note_failure($sformatf("%s expected %0d got %0d", name, exp_val, got_val));
  endfunction

  // prediction at each input and config transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (in_tvalid && in_tready)
        status_q.push_back(predict_status(cmd_t'(in_tuser), in_tdata[7:0], in_tdata[10:8],
                                          in_tdata[14:11]));
      if (cfg_we) write_model_reg(cfg_index, cfg_wdata);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      held_seen += out_tdata[0];
      err_seen[out_tdata[6:5]]++;
      if (status_q.size() == 0) begin
        note_failure($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = status_q.pop_front();
        check_field("message_ready", want.ready, out_tdata[0]);
        check_field("item_count", want.count, out_tdata[4:1]);
        check_field("error_code", int'(want.err), out_tdata[6:5]);
        check_field("read_char", want.rc, out_tdata[14:7]);
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
    else if (out_tvalid && out_tready && rx_pressure) hold_cycles = $urandom_range(0, 11);
    out_tready <= (hold_cycles == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("delimited_message_receiver_core verification failed");
      $finish;
    end
  end

  task automatic send_item(cmd_t cmd, logic [7:0] b, logic [2:0] it, logic [3:0] ch);
    int gap;
    gap = tx_pressure ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, ch, it, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_char(logic [7:0] b);
    send_item(CMD_PUSH, b, 3'($urandom), 4'($urandom));
  endtask

  task automatic read_at(int it, int ch);
    send_item(CMD_READ, 8'($urandom), 3'(it), 4'(ch));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_q.size() > 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_chars(logic [7:0] o, logic [7:0] c, logic [7:0] s);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_index <= REG_STOP;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= REG_SEP;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] content_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == open_char || c == close_char || c == split_char || is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_NL;
  endfunction

  task automatic fill_item(int len);
    for (int j = 0; j < len; j++) push_char(content_char());
  endtask

  task automatic test_framing();
    send_text("x");
    send_text(" <a b,\nc>");
    read_at(0, 1);
    read_at(1, 0);
    read_at(1, 1);
    read_at(2, 0);
    push_char("z");
    send_item(CMD_NOP, 8'hff, 3'd7, 4'd15);
    send_item(CMD_CLEAR, 8'h00, 3'd0, 4'd0);
    read_at(0, 0);
  endtask

  task automatic test_framing_errors();
    send_text("<<");
    send_text("<a,,");
    send_text("<a,>");
    read_at(0, 0);
    push_char(CHAR_NUL);
    send_item(CMD_CLEAR, 8'h00, 3'd0, 4'd0);
    send_text("<>");
    send_item(CMD_CLEAR, 8'h00, 3'd0, 4'd0);
  endtask

  task automatic test_capacity();
    push_char(open_char);
    for (int i = 0; i < MAX_ITEMS; i++) begin
      fill_item(MAX_ITEM_LEN);
      push_char(i < MAX_ITEMS - 1 ? split_char : close_char);
    end
    read_at(MAX_ITEMS - 1, MAX_ITEM_LEN - 1);
    read_at(0, 0);
    send_item(CMD_CLEAR, 8'h00, 3'd0, 4'd0);
    push_char(open_char);
    for (int i = 0; i < MAX_ITEMS; i++) begin
      fill_item(1);
      push_char(split_char);
    end
    push_char(open_char);
    fill_item(MAX_ITEM_LEN + 1);
    push_char(open_char);
    fill_item(MAX_ITEM_LEN);
    push_char(blank_char());
  endtask

  task automatic test_registers();
    logic [7:0] sets [5][3];
    sets = '{'{8'h00, 8'hff, 8'h01}, '{8'hff, 8'h01, 8'h00}, '{CHAR_SPACE, CHAR_NL, 8'h80},
             '{8'h23, 8'h23, 8'h23}, '{START_RESET, STOP_RESET, SEP_RESET}};
    foreach (sets[k]) begin
      quiesce();
      set_chars(sets[k][0], sets[k][1], sets[k][2]);
      push_char(blank_char());
      push_char(open_char);
      fill_item(2);
      push_char(split_char);
      fill_item(1);
      push_char(close_char);
      read_at(0, 1);
      read_at(1, 0);
      send_item(CMD_CLEAR, 8'h00, 3'd0, 4'd0);
    end
  endtask

  task automatic random_message();
    int fault;
    int n_items;
    int lens [MAX_ITEMS];
    int len;
    int it;
    int r;
    fault   = ($urandom_range(0, 3) == 0) ? $urandom_range(FAULT_OVERLONG, FAULT_FULL_BLNK)
                                          : FAULT_NONE;
    n_items = ($urandom_range(0, 7) == 0) ? MAX_ITEMS : $urandom_range(0, 5);
    if (fault == FAULT_TOO_MANY) n_items = MAX_ITEMS;
    if (fault != FAULT_NONE && n_items == 0) n_items = 1;
    lens = '{default: 1};
    if ($urandom_range(0, 3) == 0) push_char(blank_char());
    push_char(open_char);
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 9);
      len = (r < 7) ? $urandom_range(1, 4) : (r < 8) ? MAX_ITEM_LEN : $urandom_range(5, 15);
      if (i == n_items - 1 && fault == FAULT_OVERLONG) len = MAX_ITEM_LEN + 1;
      if (i == n_items - 1 && fault == FAULT_FULL_BLNK) len = MAX_ITEM_LEN;
      for (int j = 0; j < len; j++) begin
        push_char(content_char());
        if (j + 1 < MAX_ITEM_LEN && $urandom_range(0, 9) == 0) push_char(blank_char());
      end
      lens[i] = len;
      if (i == n_items - 1) begin
        case (fault)
          FAULT_OVERLONG:  return;
          FAULT_FULL_BLNK: begin push_char(blank_char()); return; end
          FAULT_TOO_MANY:  begin push_char(split_char); return; end
          FAULT_EMPTY:     begin push_char(split_char); push_char(split_char); return; end
          FAULT_RESTART:   begin push_char(open_char); return; end
          default: ;
        endcase
      end else begin
        if (fault == FAULT_STRAY && i == 0) push_char(8'($urandom));
        push_char(split_char);
      end
    end
    if (n_items > 0 && n_items < MAX_ITEMS && $urandom_range(0, 9) == 0) push_char(split_char);
    push_char(close_char);
    repeat ($urandom_range(2, 8)) begin
      if (n_items > 0 && $urandom_range(0, 4) != 0) begin
        it = $urandom_range(0, n_items - 1);
        read_at(it, $urandom_range(0, lens[it] - 1));
      end else begin
        read_at($urandom_range(0, 7), $urandom_range(0, 15));
      end
    end
    if ($urandom_range(0, 4) == 0) push_char(8'($urandom));
    if ($urandom_range(0, 9) != 0) send_item(CMD_CLEAR, 8'($urandom), 3'($urandom), 4'($urandom));
  endtask

  task automatic random_chars();
    logic [7:0] o;
    logic [7:0] c;
    logic [7:0] s;
    if ($urandom_range(0, 9) == 0) begin
      o = 8'($urandom);
      c = 8'($urandom);
      s = 8'($urandom);
    end else begin
      o = 8'($urandom_range(33, 255));
      do c = 8'($urandom_range(33, 255)); while (c == o);
      do s = 8'($urandom_range(33, 255)); while (s == o || s == c);
    end
    set_chars(o, c, s);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int next_cfg;
    stop_at  = items_sent + RANDOM_ITEMS;
    next_cfg = items_sent + CFG_PERIOD;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        quiesce();
        random_chars();
        next_cfg += CFG_PERIOD;
      end
      tx_pressure = ($urandom_range(0, 4) != 0);
      rx_pressure = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 4))
          send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 3'($urandom), 4'($urandom));
      else
        random_message();
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    tx_pressure = 1'b1;
    rx_pressure = 1'b1;
    hold_cycles = 0;
    idle_cycles = 0;
    err_seen    = '{default: 0};
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_framing();
    test_framing_errors();
    test_capacity();
    test_registers();
    test_random_traffic();

    quiesce();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (status_q.size() != 0) note_failure("results still pending at end of run");
    $display("%0d input transfers, %0d results checked, %0d with a message held",
             items_sent, results_seen, held_seen);
    $display("error codes reported: illegal %0d, too many %0d, length %0d; %0d mismatches",
             err_seen[ERR_ILLEGAL], err_seen[ERR_COUNT], err_seen[ERR_LENGTH], mismatches);
    if (mismatches == 0) begin
      $display("delimited_message_receiver_core verification clean");
    end else begin
      $display("delimited_message_receiver_core verification failed");
    end
    $finish;
  end

endmodule
